/* src/qrv_pkg.sv */
// Shared types and helpers for the quaternion vector rotation pipeline.
// Depends on nothing; every other file in src uses it by scoped name.
package qrv_pkg;

  // Signed Q16.16 word, full 32x32 product and a product sum with headroom.
  typedef logic signed [31:0] fix_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] acc_t;

  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_QUAT_W = 2'd0;
  localparam cfg_idx_t CFG_QUAT_X = 2'd1;
  localparam cfg_idx_t CFG_QUAT_Y = 2'd2;
  localparam cfg_idx_t CFG_QUAT_Z = 2'd3;

  localparam fix_t QUAT_W_RST = 32'sd65536;
  localparam fix_t FIX_MAX    = 32'sh7fffffff;
  localparam fix_t FIX_MIN    = 32'sh80000000;

  typedef struct packed {
    fix_t w;
    fix_t x;
    fix_t y;
    fix_t z;
  } quat_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
  } vec3_t;

  // Control tag that travels with each item down the pipe.
  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

  // Sign-extend a product to accumulator width.
  function automatic acc_t ext(input prod_t p);
    return $signed({{2{p[63]}}, p});
  endfunction

  // Arithmetic shift right 16 (floor), then saturate to 32 bits.
  function automatic fix_t shr_sat(input acc_t s);
    logic [49:0] sh;
    sh = s[65:16];
    if ((&sh[49:31]) || !(|sh[49:31])) begin
      return $signed(sh[31:0]);
    end else if (sh[49]) begin
      return FIX_MIN;
    end else begin
      return FIX_MAX;
    end
  endfunction

endpackage

/* src/qrv_qv_mult.sv */
// First product stage: the twelve partial products of q * (0, v).
// Depends on qrv_pkg.
module qrv_qv_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  qrv_pkg::tag_t       tag_in,
  input  qrv_pkg::quat_t      quat,
  input  qrv_pkg::vec3_t      vec,
  output qrv_pkg::tag_t       tag_r,
  output qrv_pkg::prod_t      prod_r [0:11]
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else if (adv) begin
      tag_r <= tag_in;
    end
  end

  // Order: tw terms, tx terms, ty terms, tz terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r[0]   <= qrv_pkg::prod_t'(quat.x) * qrv_pkg::prod_t'(vec.x);
      prod_r[1]   <= qrv_pkg::prod_t'(quat.y) * qrv_pkg::prod_t'(vec.y);
      prod_r[2]   <= qrv_pkg::prod_t'(quat.z) * qrv_pkg::prod_t'(vec.z);
      prod_r[3]   <= qrv_pkg::prod_t'(quat.w) * qrv_pkg::prod_t'(vec.x);
      prod_r[4]   <= qrv_pkg::prod_t'(quat.y) * qrv_pkg::prod_t'(vec.z);
      prod_r[5]   <= qrv_pkg::prod_t'(quat.z) * qrv_pkg::prod_t'(vec.y);
      prod_r[6]   <= qrv_pkg::prod_t'(quat.w) * qrv_pkg::prod_t'(vec.y);
      prod_r[7]   <= qrv_pkg::prod_t'(quat.x) * qrv_pkg::prod_t'(vec.z);
      prod_r[8]   <= qrv_pkg::prod_t'(quat.z) * qrv_pkg::prod_t'(vec.x);
      prod_r[9]   <= qrv_pkg::prod_t'(quat.w) * qrv_pkg::prod_t'(vec.z);
      prod_r[10]  <= qrv_pkg::prod_t'(quat.x) * qrv_pkg::prod_t'(vec.y);
      prod_r[11]  <= qrv_pkg::prod_t'(quat.y) * qrv_pkg::prod_t'(vec.x);
    end
  end

endmodule

/* src/qrv_t_sum.sv */
// Second stage: signed sums of the first products, shift and saturate to t.
// Depends on qrv_pkg.
module qrv_t_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  qrv_pkg::tag_t       tag_in,
  input  qrv_pkg::prod_t      prod [0:11],
  output qrv_pkg::tag_t       tag_r,
  output qrv_pkg::quat_t      t_r
);

  qrv_pkg::acc_t sum_w, sum_x, sum_y, sum_z;

  always_comb begin
    sum_w = -qrv_pkg::ext(prod[0]) - qrv_pkg::ext(prod[1]) - qrv_pkg::ext(prod[2]);
    sum_x =  qrv_pkg::ext(prod[3]) + qrv_pkg::ext(prod[4]) - qrv_pkg::ext(prod[5]);
    sum_y =  qrv_pkg::ext(prod[6]) - qrv_pkg::ext(prod[7]) + qrv_pkg::ext(prod[8]);
    sum_z =  qrv_pkg::ext(prod[9]) + qrv_pkg::ext(prod[10]) - qrv_pkg::ext(prod[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else if (adv) begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r.w      <= qrv_pkg::shr_sat(sum_w);
      t_r.x      <= qrv_pkg::shr_sat(sum_x);
      t_r.y      <= qrv_pkg::shr_sat(sum_y);
      t_r.z      <= qrv_pkg::shr_sat(sum_z);
    end
  end

endmodule

/* src/qrv_tq_mult.sv */
// Third stage: the twelve partial products of t * conj(q), signs applied later.
// Depends on qrv_pkg.
module qrv_tq_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  qrv_pkg::tag_t       tag_in,
  input  qrv_pkg::quat_t      t,
  input  qrv_pkg::quat_t      quat,
  output qrv_pkg::tag_t       tag_r,
  output qrv_pkg::prod_t      prod_r [0:11]
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else if (adv) begin
      tag_r <= tag_in;
    end
  end

  // Four terms each for rx, ry, rz; the scalar part of r is not needed.
  always_ff @(posedge clk) begin
    if (adv) begin
      // rx
      prod_r[0]   <= qrv_pkg::prod_t'(t.w) * qrv_pkg::prod_t'(quat.x);
      prod_r[1]   <= qrv_pkg::prod_t'(t.x) * qrv_pkg::prod_t'(quat.w);
      prod_r[2]   <= qrv_pkg::prod_t'(t.y) * qrv_pkg::prod_t'(quat.z);
      prod_r[3]   <= qrv_pkg::prod_t'(t.z) * qrv_pkg::prod_t'(quat.y);
      // ry
      prod_r[4]   <= qrv_pkg::prod_t'(t.w) * qrv_pkg::prod_t'(quat.y);
      prod_r[5]   <= qrv_pkg::prod_t'(t.x) * qrv_pkg::prod_t'(quat.z);
      prod_r[6]   <= qrv_pkg::prod_t'(t.y) * qrv_pkg::prod_t'(quat.w);
      prod_r[7]   <= qrv_pkg::prod_t'(t.z) * qrv_pkg::prod_t'(quat.x);
      // rz
      prod_r[8]   <= qrv_pkg::prod_t'(t.w) * qrv_pkg::prod_t'(quat.z);
      prod_r[9]   <= qrv_pkg::prod_t'(t.x) * qrv_pkg::prod_t'(quat.y);
      prod_r[10]  <= qrv_pkg::prod_t'(t.y) * qrv_pkg::prod_t'(quat.x);
      prod_r[11]  <= qrv_pkg::prod_t'(t.z) * qrv_pkg::prod_t'(quat.w);
    end
  end

endmodule

/* src/qrv_r_sum.sv */
// Last stage: signed sums for the vector part of r, shift, saturate, output register.
// Depends on qrv_pkg.
module qrv_r_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  qrv_pkg::tag_t       tag_in,
  input  qrv_pkg::prod_t      prod [0:11],
  output qrv_pkg::tag_t       tag_r,
  output qrv_pkg::vec3_t      rot_r
);

  qrv_pkg::acc_t sum_x, sum_y, sum_z;

  // Conjugate signs folded in here; -2^31 components stay exact.
  always_comb begin
    sum_x = -qrv_pkg::ext(prod[0]) + qrv_pkg::ext(prod[1])
            - qrv_pkg::ext(prod[2]) + qrv_pkg::ext(prod[3]);
    sum_y = -qrv_pkg::ext(prod[4]) + qrv_pkg::ext(prod[5])
            + qrv_pkg::ext(prod[6]) - qrv_pkg::ext(prod[7]);
    sum_z = -qrv_pkg::ext(prod[8]) - qrv_pkg::ext(prod[9])
            + qrv_pkg::ext(prod[10]) + qrv_pkg::ext(prod[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else if (adv) begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_r.x    <= qrv_pkg::shr_sat(sum_x);
      rot_r.y    <= qrv_pkg::shr_sat(sum_y);
      rot_r.z    <= qrv_pkg::shr_sat(sum_z);
    end
  end

endmodule

/* src/quaternion_rotate_vec3_core.sv */
// Quaternion rotation of signed Q16.16 3-vectors: r = q * (0,v) * conj(q).
// Depends on qrv_pkg, qrv_qv_mult, qrv_t_sum, qrv_tq_mult, qrv_r_sum.
//
// Takes one vector per cycle while in_stall is low. Each accepted input vector is
// registered in turn by stages 1, 2, 3 and 4, the last of which is the output
// register that presents its rotated result with out_valid high; order
// is kept and last_out is copied from last_in. The pipe has four register stages:
// the twelve 32x32 products of q*(0,v), their signed sums shifted right 16 (floor)
// and saturated into t, the twelve 32x32 products of t*conj(q), and the final sums
// with shift and saturate, which form the output register. Every stage takes a new
// vector each cycle, so throughput is one vector per cycle. The whole pipe advances
// together: it holds only while a result sits in the output register and out_stall
// is high, and in_stall is exactly that condition. The quaternion registers
// (index 0..3 = w, x, y, z; reset 1.0, 0, 0, 0) are used live by both product
// ranks, so write them only while the pipe is empty. cfg_ready is always high. The
// quaternion is not normalized; sums are exact before each shift.
module quaternion_rotate_vec3_core (
  input  logic                      clk,
  input  logic                      rst_n,
  // input vectors
  input  logic                      in_valid,
  output logic                      in_stall,
  input  qrv_pkg::fix_t             in_vec_x,
  input  qrv_pkg::fix_t             in_vec_y,
  input  qrv_pkg::fix_t             in_vec_z,
  input  logic                      in_last_in,
  // rotated vectors
  output logic                      out_valid,
  input  logic                      out_stall,
  output qrv_pkg::fix_t             out_rot_x,
  output qrv_pkg::fix_t             out_rot_y,
  output qrv_pkg::fix_t             out_rot_z,
  output logic                      out_last_out,
  // quaternion register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  qrv_pkg::cfg_idx_t         cfg_index,
  input  qrv_pkg::fix_t             cfg_data
);

  qrv_pkg::quat_t quat_r;

  qrv_pkg::tag_t  in_tag;
  qrv_pkg::vec3_t in_vec;
  qrv_pkg::tag_t  s1_tag, s2_tag, s3_tag, s4_tag;
  qrv_pkg::prod_t s1_prod [0:11];
  qrv_pkg::prod_t s3_prod [0:11];
  qrv_pkg::quat_t s2_t;
  qrv_pkg::vec3_t s4_rot;
  logic           adv;

  // Global advance: only a waiting result under back-pressure holds the pipe.
  assign adv       = !(s4_tag.vld && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  assign in_tag = {in_valid, in_last_in};
  assign in_vec = {in_vec_x, in_vec_y, in_vec_z};

  // Quaternion registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r.w <= qrv_pkg::QUAT_W_RST;
      quat_r.x <= '0;
      quat_r.y <= '0;
      quat_r.z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qrv_pkg::CFG_QUAT_W: quat_r.w <= cfg_data;
        qrv_pkg::CFG_QUAT_X: quat_r.x <= cfg_data;
        qrv_pkg::CFG_QUAT_Y: quat_r.y <= cfg_data;
        qrv_pkg::CFG_QUAT_Z: quat_r.z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: q * (0,v) products
  qrv_qv_mult u_qv_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .tag_in (in_tag),
    .quat   (quat_r),
    .vec    (in_vec),
    .tag_r  (s1_tag),
    .prod_r (s1_prod)
  );

  // Stage 2: t = shift/saturate of the signed sums
  qrv_t_sum u_t_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .tag_in (s1_tag),
    .prod   (s1_prod),
    .tag_r  (s2_tag),
    .t_r    (s2_t)
  );

  // Stage 3: t * conj(q) products
  qrv_tq_mult u_tq_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .tag_in (s2_tag),
    .t      (s2_t),
    .quat   (quat_r),
    .tag_r  (s3_tag),
    .prod_r (s3_prod)
  );

  // Stage 4: vector part of r; this is the output register
  qrv_r_sum u_r_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .tag_in (s3_tag),
    .prod   (s3_prod),
    .tag_r  (s4_tag),
    .rot_r  (s4_rot)
  );

  assign out_valid    = s4_tag.vld;
  assign out_last_out = s4_tag.last;
  assign out_rot_x    = s4_rot.x;
  assign out_rot_y    = s4_rot.y;
  assign out_rot_z    = s4_rot.z;

`ifndef SYNTH
  // While reset stays off and the pipe advances, the output valid is the input
  // valid carried through the stage registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
     $past(adv, 1) && $past(adv, 2) && $past(adv, 3) && $past(adv, 4))
    |-> (out_valid == $past(in_valid, 4)))
    else $error("pipeline valid lost or invented");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 4) && $past(adv, 1) && $past(adv, 2) && $past(adv, 3) &&
     $past(adv, 4) && out_valid)
    |-> (out_last_out == $past(in_last_in, 4)))
    else $error("last flag misrouted through pipeline");

  // While the result is held, every stage holds too.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(s3_tag) && $stable(s2_tag) && $stable(s1_tag)))
    else $error("pipeline stage moved during stall");

  a_cfg_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> (quat_r.w == qrv_pkg::QUAT_W_RST && quat_r.x == '0 &&
                       quat_r.y == '0 && quat_r.z == '0))
    else $error("quaternion registers not at reset value");
`endif

endmodule
